FILE: rtl/index_word_tokenizer_filter_defines.svh
// Assertion macros shared by the word tokenizer RTL.
`ifndef INDEX_WORD_TOKENIZER_FILTER_DEFINES_SVH
`define INDEX_WORD_TOKENIZER_FILTER_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define IWTF_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define IWTF_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/iwtf_pkg.sv
// Package with constants, codes and character classes for the word tokenizer.
package iwtf_pkg;

   localparam int MAX_LETTERS_DEF = 48;
   localparam int LINE_BITS_DEF   = 20;
   localparam int BYTE_W          = 8;
   localparam int LINE_NUM_W      = 20;

   localparam logic ACTION_TEXT = 1'b0;
   localparam logic ACTION_END  = 1'b1;

   localparam logic [BYTE_W-1:0] CH_PERIOD   = 8'h2E;
   localparam logic [BYTE_W-1:0] CH_QUESTION = 8'h3F;
   localparam logic [BYTE_W-1:0] CH_BANG     = 8'h21;
   localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
   localparam logic [BYTE_W-1:0] CH_NEWLINE  = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_TAB      = 8'h09;
   localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_UPPER_A  = 8'h41;
   localparam logic [BYTE_W-1:0] CH_UPPER_Z  = 8'h5A;
   localparam logic [BYTE_W-1:0] CH_LOWER_A  = 8'h61;
   localparam logic [BYTE_W-1:0] CH_LOWER_Z  = 8'h7A;
   localparam logic [BYTE_W-1:0] CH_ZERO     = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE     = 8'h39;
   localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'h20;

   function automatic logic is_upper(input logic [BYTE_W-1:0] b);
      return (b >= CH_UPPER_A) && (b <= CH_UPPER_Z);
   endfunction

   function automatic logic is_letter(input logic [BYTE_W-1:0] b);
      return is_upper(b) || ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z));
   endfunction

   function automatic logic is_digit(input logic [BYTE_W-1:0] b);
      return (b >= CH_ZERO) && (b <= CH_NINE);
   endfunction

   function automatic logic is_space(input logic [BYTE_W-1:0] b);
      return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
   endfunction

   function automatic logic is_stop_mark(input logic [BYTE_W-1:0] b);
      return (b == CH_PERIOD) || (b == CH_QUESTION) || (b == CH_BANG);
   endfunction

   function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] b);
      return is_upper(b) ? (b + CASE_OFFSET) : b;
   endfunction

endpackage

FILE: rtl/iwtf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module iwtf_ram #(
   parameter int Width = 8,
   parameter int Depth = 96
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/index_word_tokenizer_filter.sv
// Top level of the word tokenizer: letter collection, word filter and letter emitter.
// Takes one text item per cycle unless stalled; a kept word then leaves through a read stage
// and output register, one letter per cycle when not stalled, from the RAM's single read port.
// Word RAM holds two word banks, so a word fills while the previous one drains; an item
// that ends a word stalls only while the previous kept word is still being read out.
// Synchronous reset clears control state at once; the RAM has no reset and no clearing pass.
`include "index_word_tokenizer_filter_defines.svh"

module index_word_tokenizer_filter #(
   parameter int MaxLetters = iwtf_pkg::MAX_LETTERS_DEF,
   parameter int LineBits   = iwtf_pkg::LINE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [iwtf_pkg::BYTE_W-1:0]         req_text_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [iwtf_pkg::BYTE_W-1:0]         rsp_letter,
   output logic [iwtf_pkg::LINE_NUM_W-1:0]     rsp_line_number,
   output logic                                rsp_last_letter
);

   import iwtf_pkg::*;

   localparam int LEN_W    = $clog2(MaxLetters + 1);
   localparam int IDX_W    = $clog2(MaxLetters);
   localparam int DEPTH    = 2 * MaxLetters;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int EXT_W    = LineBits + LINE_NUM_W;

   localparam logic [LEN_W-1:0]    LEN_MAX   = LEN_W'(MaxLetters);
   localparam logic [ADDR_W-1:0]   BANK_OFS  = ADDR_W'(MaxLetters);
   localparam logic [LineBits-1:0] LINE_ONE  = LineBits'(1);
   localparam logic [LineBits-1:0] LINE_SAT  = {LineBits{1'b1}};

   // Word collection state.
   logic [LEN_W-1:0]      word_len_ff, word_len_in;
   logic [LineBits-1:0]   line_ff, line_in;
   logic                  sent_start_ff, sent_start_in;
   logic [BYTE_W-1:0]     prev_byte_ff, prev_byte_in;
   logic                  digit_before_ff, digit_before_in;
   logic                  first_upper_ff, first_upper_in;
   logic                  fill_bank_ff, fill_bank_in;

   // Emitter state.
   logic                  emit_busy_ff, emit_busy_in;
   logic [LEN_W-1:0]      emit_idx_ff, emit_idx_in;
   logic [LEN_W-1:0]      emit_len_ff, emit_len_in;
   logic [LINE_NUM_W-1:0] emit_line_ff, emit_line_in;
   logic                  emit_bank_ff, emit_bank_in;

   // Read stage and output register.
   logic                  s1_valid_ff, s1_valid_in;
   logic [LINE_NUM_W-1:0] s1_line_ff, s1_line_in;
   logic                  s1_last_ff, s1_last_in;
   logic                  out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]     out_letter_ff, out_letter_in;
   logic [LINE_NUM_W-1:0] out_line_ff, out_line_in;
   logic                  out_last_ff, out_last_in;

   logic                  byte_is_letter;
   logic                  ends_word;
   logic                  accept;
   logic                  keep;
   logic                  load;
   logic                  issue;
   logic                  emit_last;
   logic                  s1_move;
   logic [EXT_W-1:0]      line_ext;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ADDR_W-1:0]     rd_addr;
   logic [BYTE_W-1:0]     rd_data;

   assign byte_is_letter = is_letter(req_text_byte);
   assign ends_word      = (req_action == ACTION_END) || !byte_is_letter;
   assign req_stall      = emit_busy_ff && ends_word && (word_len_ff != '0);
   assign accept         = req_valid && !req_stall;

   assign keep = (word_len_ff != '0) && !digit_before_ff &&
                 !((req_action == ACTION_TEXT) && is_digit(req_text_byte)) &&
                 !(first_upper_ff && !sent_start_ff);
   assign load = accept && ends_word && keep;

   assign line_ext  = EXT_W'(line_ff);
   assign emit_last = (emit_idx_ff + LEN_W'(1)) == emit_len_ff;
   assign s1_move   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign issue     = emit_busy_ff && (!s1_valid_ff || s1_move);

   assign wr_en   = accept && (req_action == ACTION_TEXT) && byte_is_letter &&
                    (word_len_ff < LEN_MAX);
   assign wr_addr = ADDR_W'(word_len_ff[IDX_W-1:0]) + (fill_bank_ff ? BANK_OFS : '0);
   assign rd_addr = ADDR_W'(emit_idx_ff[IDX_W-1:0]) + (emit_bank_ff ? BANK_OFS : '0);

   iwtf_ram #(
      .Width (BYTE_W),
      .Depth (DEPTH)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (to_lower(req_text_byte)),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      word_len_in     = word_len_ff;
      line_in         = line_ff;
      sent_start_in   = sent_start_ff;
      prev_byte_in    = prev_byte_ff;
      digit_before_in = digit_before_ff;
      first_upper_in  = first_upper_ff;
      fill_bank_in    = load ? !fill_bank_ff : fill_bank_ff;
      if (accept) begin
         if (req_action == ACTION_END) begin
            word_len_in     = '0;
            line_in         = LINE_ONE;
            sent_start_in   = 1'b1;
            prev_byte_in    = '0;
            digit_before_in = 1'b0;
         end else if (byte_is_letter) begin
            if (word_len_ff == '0) begin
               digit_before_in = is_digit(prev_byte_ff);
               first_upper_in  = is_upper(req_text_byte);
            end
            if (word_len_ff < LEN_MAX) begin
               word_len_in = word_len_ff + LEN_W'(1);
            end
            prev_byte_in = req_text_byte;
         end else begin
            word_len_in = '0;
            if (req_text_byte == CH_NEWLINE) begin
               if (line_ff != LINE_SAT) begin
                  line_in = line_ff + LINE_ONE;
               end
               sent_start_in = 1'b1;
            end else if (is_stop_mark(prev_byte_ff) && (req_text_byte == CH_SPACE)) begin
               sent_start_in = 1'b1;
            end else if (!is_space(req_text_byte)) begin
               sent_start_in = 1'b0;
            end
            prev_byte_in = req_text_byte;
         end
      end
   end

   always_comb begin
      emit_busy_in = emit_busy_ff;
      emit_idx_in  = emit_idx_ff;
      emit_len_in  = emit_len_ff;
      emit_line_in = emit_line_ff;
      emit_bank_in = emit_bank_ff;
      if (load) begin
         emit_busy_in = 1'b1;
         emit_idx_in  = '0;
         emit_len_in  = word_len_ff;
         emit_line_in = line_ext[LINE_NUM_W-1:0];
         emit_bank_in = fill_bank_ff;
      end else if (issue) begin
         emit_idx_in = emit_idx_ff + LEN_W'(1);
         if (emit_last) begin
            emit_busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_line_in    = s1_line_ff;
      s1_last_in    = s1_last_ff;
      out_valid_in  = out_valid_ff;
      out_letter_in = out_letter_ff;
      out_line_in   = out_line_ff;
      out_last_in   = out_last_ff;
      if (issue) begin
         s1_valid_in = 1'b1;
         s1_line_in  = emit_line_ff;
         s1_last_in  = emit_last;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (s1_move) begin
         out_valid_in  = 1'b1;
         out_letter_in = rd_data;
         out_line_in   = s1_line_ff;
         out_last_in   = s1_last_ff;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_len_ff     <= '0;
         line_ff         <= LINE_ONE;
         sent_start_ff   <= 1'b1;
         prev_byte_ff    <= '0;
         digit_before_ff <= 1'b0;
         fill_bank_ff    <= 1'b0;
         emit_busy_ff    <= 1'b0;
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         word_len_ff     <= word_len_in;
         line_ff         <= line_in;
         sent_start_ff   <= sent_start_in;
         prev_byte_ff    <= prev_byte_in;
         digit_before_ff <= digit_before_in;
         fill_bank_ff    <= fill_bank_in;
         emit_busy_ff    <= emit_busy_in;
         s1_valid_ff     <= s1_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_upper_ff <= first_upper_in;
      emit_idx_ff    <= emit_idx_in;
      emit_len_ff    <= emit_len_in;
      emit_line_ff   <= emit_line_in;
      emit_bank_ff   <= emit_bank_in;
      s1_line_ff     <= s1_line_in;
      s1_last_ff     <= s1_last_in;
      out_letter_ff  <= out_letter_in;
      out_line_ff    <= out_line_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_letter      = out_letter_ff;
   assign rsp_line_number = out_line_ff;
   assign rsp_last_letter = out_last_ff;

   `IWTF_ASSERT_ALWAYS(a_word_len_bound, clock, reset, word_len_ff <= LEN_MAX)
   `IWTF_ASSERT_ALWAYS(a_line_nonzero, clock, reset, line_ff != '0)
   `IWTF_ASSERT_IMPLY(a_load_when_idle, clock, reset, load, !emit_busy_ff)
   `IWTF_ASSERT_IMPLY(a_emit_idx_bound, clock, reset, emit_busy_ff,
                      (emit_idx_ff < emit_len_ff) && (emit_len_ff != '0))

endmodule

FILE: dv/tb_index_word_tokenizer_filter.sv
// Self-checking testbench for the word tokenizer: directed and random text, letter predictor.
module tb_index_word_tokenizer_filter;
   import iwtf_pkg::*;

   localparam int LONG_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT   = 2000;
   localparam int DRAIN_CYCLES     = 20;

   typedef struct packed {
      logic [BYTE_W-1:0]     letter;
      logic [LINE_NUM_W-1:0] line;
      logic                  last;
   } letter_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_action = ACTION_TEXT;
   logic [BYTE_W-1:0]     req_text_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [BYTE_W-1:0]     rsp_letter;
   logic [LINE_NUM_W-1:0] rsp_line_number;
   logic                  rsp_last_letter;

   letter_type expected_letters[$];
   int      error_count = 0;
   int      items_sent = 0;
   int      quiet_cycles = 0;
   bit      req_idle_on = 1'b0;
   bit      rsp_idle_on = 1'b0;
   bit      long_hold_pending = 1'b0;

   logic [BYTE_W-1:0]        word_buf [MAX_LETTERS_DEF];
   int unsigned              word_len;
   logic [LINE_BITS_DEF-1:0] line_cnt;
   bit                       at_sentence_start;
   logic [BYTE_W-1:0]        prev_byte;
   bit                       digit_before;

   index_word_tokenizer_filter u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_text_byte   (req_text_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_letter      (rsp_letter),
      .rsp_line_number (rsp_line_number),
      .rsp_last_letter (rsp_last_letter)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bit byte_is_upper(input logic [BYTE_W-1:0] b);
      return b >= CH_UPPER_A && b <= CH_UPPER_Z;
   endfunction

   function automatic bit byte_is_letter(input logic [BYTE_W-1:0] b);
      return byte_is_upper(b) || (b >= CH_LOWER_A && b <= CH_LOWER_Z);
   endfunction

   function automatic bit byte_is_digit(input logic [BYTE_W-1:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
   endfunction

   function automatic bit byte_is_blank(input logic [BYTE_W-1:0] b);
      return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
   endfunction

   function void clear_tokenizer_state();
      word_len          = 0;
      line_cnt          = LINE_BITS_DEF'(1);
      at_sentence_start = 1'b1;
      prev_byte         = '0;
      digit_before      = 1'b0;
   endfunction

   function void judge_word(input bit digit_after);
      int unsigned       n;
      int unsigned       k;
      logic [BYTE_W-1:0] ch;
      letter_type        entry;
      n = word_len;
      word_len = 0;
      if (n == 0 || digit_before || digit_after) return;
      if (byte_is_upper(word_buf[0]) && !at_sentence_start) return;
      for (k = 0; k < n; k++) begin
         ch = word_buf[k];
         if (byte_is_upper(ch)) ch = ch + CASE_OFFSET;
         entry.letter = ch;
         entry.line   = line_cnt[LINE_NUM_W-1:0];
         entry.last   = (k + 1 == n);
         expected_letters.push_back(entry);
      end
   endfunction

   function void predict_item(input logic action, input logic [BYTE_W-1:0] value);
      if (action == ACTION_END) begin
         judge_word(1'b0);
         clear_tokenizer_state();
         return;
      end
      if (byte_is_letter(value)) begin
         if (word_len == 0) digit_before = byte_is_digit(prev_byte);
         if (word_len < MAX_LETTERS_DEF) begin
            word_buf[word_len] = value;
            word_len++;
         end
         prev_byte = value;
         return;
      end
      judge_word(byte_is_digit(value));
      if (value == CH_NEWLINE) begin
         if (line_cnt != '1) line_cnt++;
         at_sentence_start = 1'b1;
      end else if (value == CH_SPACE &&
                   (prev_byte == CH_PERIOD || prev_byte == CH_QUESTION ||
                    prev_byte == CH_BANG)) begin
         at_sentence_start = 1'b1;
      end else if (!byte_is_blank(value)) begin
         at_sentence_start = 1'b0;
      end
      prev_byte = value;
   endfunction

   always @(posedge clock) begin
      letter_type want;
      if (reset) begin
         clear_tokenizer_state();
         quiet_cycles = 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (req_valid && !req_stall) predict_item(req_action, req_text_byte);
         if (rsp_valid && !rsp_stall) begin
            if (expected_letters.size() == 0) begin
               $error("unexpected letter %0h on line %0d", rsp_letter, rsp_line_number);
               error_count++;
            end else begin
               want = expected_letters.pop_front();
               if (rsp_letter !== want.letter) begin
                  $error("letter: expected %0h, got %0h", want.letter, rsp_letter);
                  error_count++;
               end
               if (rsp_line_number !== want.line) begin
                  $error("line_number: expected %0d, got %0d", want.line, rsp_line_number);
                  error_count++;
               end
               if (rsp_last_letter !== want.last) begin
                  $error("last_letter: expected %0b, got %0b", want.last, rsp_last_letter);
                  error_count++;
               end
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL index_word_tokenizer_filter");
            $finish;
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_item(input logic action, input logic [BYTE_W-1:0] value);
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_action    <= action;
      req_text_byte <= value;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_text(input string text);
      int k;
      for (k = 0; k < text.len(); k++) send_item(ACTION_TEXT, text[k]);
   endtask

   task automatic wait_for_letters();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_letters.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_word();
      int unsigned       len;
      int unsigned       k;
      logic [BYTE_W-1:0] ch;
      len = ($urandom_range(0, 24) == 0) ? $urandom_range(45, 54) : $urandom_range(1, 7);
      for (k = 0; k < len; k++) begin
         ch = BYTE_W'(CH_LOWER_A + $urandom_range(0, 25));
         if ((k == 0 && $urandom_range(0, 2) == 0) || $urandom_range(0, 9) == 0)
            ch = ch - CASE_OFFSET;
         send_item(ACTION_TEXT, ch);
      end
   endtask

   task automatic send_random_break();
      case ($urandom_range(0, 11))
         0, 1: send_item(ACTION_TEXT, CH_SPACE);
         2: send_text(". ");
         3: send_text("? ");
         4: send_text("! ");
         5: send_item(ACTION_TEXT, CH_NEWLINE);
         6: send_item(ACTION_TEXT, ",");
         7: send_item(ACTION_TEXT, BYTE_W'(CH_ZERO + $urandom_range(0, 9)));
         8: send_item(ACTION_TEXT, BYTE_W'($urandom_range(CH_TAB, CH_CR)));
         9: send_item(ACTION_TEXT, BYTE_W'($urandom_range(0, 255)));
         10: send_item(ACTION_TEXT, BYTE_W'($urandom_range(128, 255)));
         default: begin
            if ($urandom_range(0, 2) == 0) send_item(ACTION_END, BYTE_W'($urandom_range(0, 255)));
            else send_item(ACTION_TEXT, CH_PERIOD);
         end
      endcase
   endtask

   task automatic test_directed_text();
      send_text("Hi\nOk. Go,Up 9x y7? Z");
      send_item(ACTION_TEXT, 8'hFF);
      send_item(ACTION_TEXT, 8'h00);
      send_item(ACTION_TEXT, "q");
      send_item(ACTION_END, 8'hFF);
      send_item(ACTION_END, 8'h00);
      wait_for_letters();
   endtask

   task automatic test_random_text(input int item_goal);
      int next_roll;
      next_roll = items_sent;
      while (items_sent < item_goal) begin
         if (items_sent >= next_roll) begin
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
            next_roll   = items_sent + 40;
         end
         if ($urandom_range(0, 4) != 0) send_random_word();
         send_random_break();
      end
      wait_for_letters();
   endtask

   task automatic test_backpressure();
      int k;
      long_hold_pending = 1'b1;
      send_item(ACTION_TEXT, CH_NEWLINE);
      for (k = 0; k < 50; k++)
         send_item(ACTION_TEXT, (k == 0) ? BYTE_W'(CH_UPPER_A + $urandom_range(0, 25))
                                         : BYTE_W'(CH_LOWER_A + $urandom_range(0, 25)));
      send_text(" the cat sat on a mat\nand ran ");
      wait_for_letters();
   endtask

   task automatic test_streaming(input int item_goal);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      while (items_sent < item_goal) begin
         send_random_word();
         send_random_break();
      end
      send_item(ACTION_END, BYTE_W'($urandom_range(0, 255)));
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      test_directed_text();
      test_random_text(340);
      test_backpressure();
      test_streaming(460);
      wait_for_letters();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS index_word_tokenizer_filter");
      end else begin
         $display("FAIL index_word_tokenizer_filter");
      end
      $finish;
   end

endmodule
